>>> rtl/cplm_pkg.sv
// ----------------------------------------------------------------------------
// cplm_pkg
// Shared types, constants and helper functions of the circular map block.
// ----------------------------------------------------------------------------
package cplm_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int PROD_W     = 2 * FRAC_BITS;
	localparam int CFG_W      = 16;

	localparam logic [FRAC_BITS:0]   TURN      = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [FRAC_BITS-1:0] HALF_TURN = {1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic [FRAC_BITS-1:0] SMALL_SEG =
		FRAC_BITS'(((1 << FRAC_BITS) + 999) / 1000);

	localparam logic CFG_POINT_COUNT = 1'b0;
	localparam logic CFG_DIST_EPS    = 1'b1;

	localparam logic [1:0] FUNC_WRITE    = 2'd0;
	localparam logic [1:0] FUNC_MAP_FWD  = 2'd1;
	localparam logic [1:0] FUNC_MAP_BACK = 2'd2;
	localparam logic [1:0] FUNC_VALIDATE = 2'd3;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_REPEAT = 2'd1;
	localparam logic [1:0] STAT_WRAPS  = 2'd2;

	typedef logic [FRAC_BITS-1:0] prog_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_MAP_FWD,
		OP_MAP_BACK,
		OP_VALIDATE
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		prog_t            src;
		prog_t            tgt;
		prog_t            x;
	} item_t;

	typedef struct packed {
		logic [1:0] fault;
		logic       wrapped;
	} chk_t;

	typedef struct packed {
		logic             pop;
		logic             mem_we;
		logic [IDX_W-1:0] raddr;
		logic             div_start;
		logic             out_load;
	} bctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_MLOAD,
		ST_MSCAN,
		ST_CALC,
		ST_MULT,
		ST_DIV,
		ST_VLOAD,
		ST_VPREV,
		ST_VSCAN,
		ST_OUT
	} state_t;

	function automatic logic in_arc(prog_t x, prog_t from, prog_t to);
		if (to >= from) begin
			return (x >= from) && (x <= to);
		end
		return (x >= from) || (x <= to);
	endfunction

	function automatic prog_t circ_dist(prog_t a, prog_t b);
		prog_t d;
		logic [FRAC_BITS:0] e;
		d = (a >= b) ? a - b : b - a;
		e = TURN - {1'b0, d};
		return ({1'b0, d} < e) ? d : e[FRAC_BITS-1:0];
	endfunction

	function automatic chk_t col_step(prog_t cur, prog_t prev, prog_t eps, chk_t c);
		chk_t r;
		r = c;
		if (c.fault == STAT_OK) begin
			if (circ_dist(cur, prev) <= eps) begin
				r.fault = STAT_REPEAT;
			end else if (cur < prev) begin
				if (c.wrapped) begin
					r.fault = STAT_WRAPS;
				end
				r.wrapped = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic prog_t reset_entry(logic [IDX_W-1:0] i);
		return (i == IDX_W'(1)) ? HALF_TURN : '0;
	endfunction

endpackage

>>> rtl/cplm_front.sv
// ----------------------------------------------------------------------------
// cplm_front
// Accepts input items, decodes the function code and queues the items.
// ----------------------------------------------------------------------------
module cplm_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic [cplm_pkg::IDX_W-1:0] entry_index,
	input  cplm_pkg::prog_t          source_value,
	input  cplm_pkg::prog_t          target_value,
	input  cplm_pkg::prog_t          progress_in,
	output logic                     q_valid,
	output cplm_pkg::item_t          q_item,
	input  logic                     q_pop
);

	cplm_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	cplm_pkg::item_t dec;
	logic            push;

	always_comb begin
		dec.idx = entry_index;
		dec.src = source_value;
		dec.tgt = target_value;
		dec.x   = progress_in;
		unique case (func)
			cplm_pkg::FUNC_WRITE:    dec.op = cplm_pkg::OP_WRITE;
			cplm_pkg::FUNC_MAP_FWD:  dec.op = cplm_pkg::OP_MAP_FWD;
			cplm_pkg::FUNC_MAP_BACK: dec.op = cplm_pkg::OP_MAP_BACK;
			default:                 dec.op = cplm_pkg::OP_VALIDATE;
		endcase
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

>>> rtl/cplm_div.sv
// ----------------------------------------------------------------------------
// cplm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cplm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cplm_pkg::PROD_W-1:0]   dividend,
	input  cplm_pkg::prog_t               divisor,
	output logic                          done,
	output logic [cplm_pkg::PROD_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(cplm_pkg::PROD_W);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [cplm_pkg::PROD_W-1:0] quo_q;
	cplm_pkg::prog_t             rem_q;
	cplm_pkg::prog_t             div_q;
	logic [cplm_pkg::FRAC_BITS:0] trial;
	logic                        ge;

	assign trial    = {rem_q, quo_q[cplm_pkg::PROD_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[cplm_pkg::PROD_W-2:0], ge};
			rem_q <= ge ? cplm_pkg::FRAC_BITS'(trial - {1'b0, div_q})
			            : trial[cplm_pkg::FRAC_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(cplm_pkg::PROD_W - 1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(cplm_pkg::PROD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/cplm_back.sv
// ----------------------------------------------------------------------------
// cplm_back
// Holds the point table and carries out write, map and validate items.
// ----------------------------------------------------------------------------
module cplm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cplm_pkg::CNT_W-1:0]    point_count,
	input  cplm_pkg::prog_t               distance_epsilon,
	input  logic                          q_valid,
	input  cplm_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cplm_pkg::prog_t               mapped_value,
	output logic [1:0]                    status
);

	localparam int IW = cplm_pkg::IDX_W;
	localparam int FB = cplm_pkg::FRAC_BITS;

	cplm_pkg::state_t state_q, state_d;
	cplm_pkg::bctl_t  ctl;
	cplm_pkg::item_t  item_q;

	logic [2*FB-1:0]  mem [cplm_pkg::MAX_POINTS];
	logic [cplm_pkg::MAX_POINTS-1:0] vld_q;
	logic [2*FB-1:0]  rd_q;
	logic             rd_vld_q;
	logic [IW-1:0]    rd_addr_q;
	cplm_pkg::prog_t  rd_src, rd_tgt, cur_x, cur_y;

	logic [cplm_pkg::CNT_W-1:0] nu;
	logic [IW-1:0]    last;
	logic [IW-1:0]    cnt_q;

	cplm_pkg::prog_t  prev_x_q, prev_y_q, first_x_q, first_y_q;
	cplm_pkg::prog_t  second_x_q, second_y_q;
	cplm_pkg::prog_t  sx_q, sy_q, ex_q, ey_q;
	cplm_pkg::prog_t  wx, wy, off;
	logic [2*FB-1:0]  prod_q;
	logic             div_done;
	logic [2*FB-1:0]  quot;

	logic             seg_done;
	cplm_pkg::prog_t  sx_d, sy_d, ex_d, ey_d;

	cplm_pkg::chk_t   chk_s_q, chk_t_q, chk_s_d, chk_t_d;

	cplm_pkg::prog_t  res_mapped_q, mapped_q;
	logic [1:0]       res_status_q, status_q;
	logic             out_valid_q;

	always_comb begin
		if (point_count == '0) begin
			nu = cplm_pkg::CNT_W'(1);
		end else if (point_count > cplm_pkg::CNT_W'(cplm_pkg::MAX_POINTS)) begin
			nu = cplm_pkg::CNT_W'(cplm_pkg::MAX_POINTS);
		end else begin
			nu = point_count;
		end
	end
	assign last = IW'(nu - 1'b1);

	assign rd_src = rd_vld_q ? rd_q[2*FB-1:FB] : cplm_pkg::reset_entry(rd_addr_q);
	assign rd_tgt = rd_vld_q ? rd_q[FB-1:0]    : cplm_pkg::reset_entry(rd_addr_q);
	assign cur_x  = (item_q.op == cplm_pkg::OP_MAP_BACK) ? rd_tgt : rd_src;
	assign cur_y  = (item_q.op == cplm_pkg::OP_MAP_BACK) ? rd_src : rd_tgt;

	assign wx  = ex_q - sx_q;
	assign wy  = ey_q - sy_q;
	assign off = item_q.x - sx_q;

	always_comb begin
		seg_done = 1'b0;
		sx_d = cur_x;
		sy_d = cur_y;
		ex_d = cur_x;
		ey_d = cur_y;
		if (cnt_q == '0) begin
			seg_done = (last == '0);
		end else if (cplm_pkg::in_arc(item_q.x, prev_x_q, cur_x)) begin
			seg_done = 1'b1;
			sx_d = prev_x_q;
			sy_d = prev_y_q;
		end else if (cnt_q == last) begin
			seg_done = 1'b1;
			if (cplm_pkg::in_arc(item_q.x, cur_x, first_x_q)) begin
				ex_d = first_x_q;
				ey_d = first_y_q;
			end else begin
				sx_d = first_x_q;
				sy_d = first_y_q;
				ex_d = (cnt_q == IW'(1)) ? cur_x : second_x_q;
				ey_d = (cnt_q == IW'(1)) ? cur_y : second_y_q;
			end
		end
	end

	assign chk_s_d = cplm_pkg::col_step(rd_src, prev_x_q, distance_epsilon, chk_s_q);
	assign chk_t_d = cplm_pkg::col_step(rd_tgt, prev_y_q, distance_epsilon, chk_t_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cplm_pkg::ST_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						cplm_pkg::OP_WRITE:    state_d = cplm_pkg::ST_WRITE;
						cplm_pkg::OP_VALIDATE: state_d = (last == '0) ? cplm_pkg::ST_OUT
						                                              : cplm_pkg::ST_VLOAD;
						default:               state_d = cplm_pkg::ST_MLOAD;
					endcase
				end
			end
			cplm_pkg::ST_WRITE: state_d = cplm_pkg::ST_OUT;
			cplm_pkg::ST_MLOAD: state_d = cplm_pkg::ST_MSCAN;
			cplm_pkg::ST_MSCAN: begin
				if (seg_done) begin
					state_d = cplm_pkg::ST_CALC;
				end
			end
			cplm_pkg::ST_CALC: begin
				state_d = (wx < cplm_pkg::SMALL_SEG) ? cplm_pkg::ST_OUT : cplm_pkg::ST_MULT;
			end
			cplm_pkg::ST_MULT: state_d = cplm_pkg::ST_DIV;
			cplm_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = cplm_pkg::ST_OUT;
				end
			end
			cplm_pkg::ST_VLOAD: state_d = cplm_pkg::ST_VPREV;
			cplm_pkg::ST_VPREV: state_d = cplm_pkg::ST_VSCAN;
			cplm_pkg::ST_VSCAN: begin
				if (cnt_q == last) begin
					state_d = cplm_pkg::ST_OUT;
				end
			end
			cplm_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = cplm_pkg::ST_IDLE;
				end
			end
			default: state_d = cplm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			cplm_pkg::ST_IDLE:  ctl.pop = q_valid;
			cplm_pkg::ST_WRITE: ctl.mem_we = 1'b1;
			cplm_pkg::ST_MLOAD: ctl.raddr = '0;
			cplm_pkg::ST_MSCAN: ctl.raddr = cnt_q + 1'b1;
			cplm_pkg::ST_MULT:  ctl.div_start = 1'b1;
			cplm_pkg::ST_VLOAD: ctl.raddr = last;
			cplm_pkg::ST_VPREV: ctl.raddr = '0;
			cplm_pkg::ST_VSCAN: ctl.raddr = cnt_q + 1'b1;
			cplm_pkg::ST_OUT:   ctl.out_load = !out_valid_q || !out_stall;
			default:            ctl = '0;
		endcase
	end

	assign q_pop = ctl.pop;

	always_ff @(posedge clk) begin
		if (ctl.mem_we) begin
			mem[item_q.idx] <= {item_q.src, item_q.tgt};
		end
		rd_q      <= mem[ctl.raddr];
		rd_addr_q <= ctl.raddr;
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			item_q       <= q_item;
			res_mapped_q <= '0;
			res_status_q <= cplm_pkg::STAT_OK;
		end
		if (ctl.out_load) begin
			mapped_q <= res_mapped_q;
			status_q <= res_status_q;
		end
		unique case (state_q)
			cplm_pkg::ST_MSCAN: begin
				prev_x_q <= cur_x;
				prev_y_q <= cur_y;
				cnt_q    <= cnt_q + 1'b1;
				if (cnt_q == '0) begin
					first_x_q <= cur_x;
					first_y_q <= cur_y;
				end
				if (cnt_q == IW'(1)) begin
					second_x_q <= cur_x;
					second_y_q <= cur_y;
				end
				sx_q <= sx_d;
				sy_q <= sy_d;
				ex_q <= ex_d;
				ey_q <= ey_d;
			end
			cplm_pkg::ST_CALC: begin
				res_mapped_q <= sy_q + (wy >> 1);
				prod_q       <= wy * off;
			end
			cplm_pkg::ST_DIV: begin
				res_mapped_q <= sy_q + quot[FB-1:0];
			end
			cplm_pkg::ST_VPREV: begin
				prev_x_q <= rd_src;
				prev_y_q <= rd_tgt;
				chk_s_q  <= '0;
				chk_t_q  <= '0;
			end
			cplm_pkg::ST_VSCAN: begin
				prev_x_q     <= rd_src;
				prev_y_q     <= rd_tgt;
				chk_s_q      <= chk_s_d;
				chk_t_q      <= chk_t_d;
				cnt_q        <= cnt_q + 1'b1;
				res_status_q <= (chk_s_d.fault != cplm_pkg::STAT_OK) ? chk_s_d.fault
				                                                     : chk_t_d.fault;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cplm_pkg::ST_IDLE;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= vld_q[ctl.raddr];
			if (ctl.mem_we) begin
				vld_q[item_q.idx] <= 1'b1;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	cplm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (prod_q),
		.divisor  (wx),
		.done     (div_done),
		.quotient (quot)
	);

	assign out_valid    = out_valid_q;
	assign mapped_value = mapped_q;
	assign status       = status_q;

endmodule

>>> rtl/circular_piecewise_linear_map.sv
// ----------------------------------------------------------------------------
// circular_piecewise_linear_map
// Maps progress values around a circle through a table of up to 16 points.
// ----------------------------------------------------------------------------
// Items enter on the input channel (in_valid, in_stall) and each one gives
// exactly one result on the output channel (out_valid, out_stall), in order.
// A front queue of two items accepts input while the back end works.
// A write item updates one table entry, a validate item reads every point
// (none with a single point), and a forward or back map walks the table
// (one table read per cycle) until it finds the segment, then uses the
// one-bit-per-cycle divider when the segment is wide enough. The back end
// works on one item at a time, so throughput is set by the table walk and
// the divider.
// After reset the table holds the identity map with two points, the point
// count is 2 and the distance epsilon is 1. While the receiver stalls, the
// result is held, the back end waits, and the input stalls once the queue
// is full. Configuration writes go through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module circular_piecewise_linear_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [cplm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [cplm_pkg::IDX_W-1:0]    entry_index,
	input  logic [15:0]                   source_value,
	input  logic [15:0]                   target_value,
	input  logic [15:0]                   progress_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   mapped_value,
	output logic [1:0]                    status
);

	logic [4:0]      point_count_q;
	cplm_pkg::prog_t eps_q;
	logic            q_valid;
	logic            q_pop;
	cplm_pkg::item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= 5'd2;
			eps_q         <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cplm_pkg::CFG_POINT_COUNT: point_count_q <= cfg_data[4:0];
				cplm_pkg::CFG_DIST_EPS:    eps_q <= cfg_data[15:0];
				default:                   eps_q <= eps_q;
			endcase
		end
	end

	cplm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.entry_index  (entry_index),
		.source_value (source_value),
		.target_value (target_value),
		.progress_in  (progress_in),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	cplm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.point_count      (point_count_q),
		.distance_epsilon (eps_q),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.mapped_value     (mapped_value),
		.status           (status)
	);

endmodule

>>> rtl/cplm_checker.sv
// ----------------------------------------------------------------------------
// cplm_checker
// Port-level checks of the circular map block, bound to its top level.
// ----------------------------------------------------------------------------
module cplm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] mapped_value,
	input  logic [1:0]  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mapped_value) && $stable(status))
		else $error("Stalled result changed.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= cplm_pkg::STAT_WRAPS)
		else $error("Undefined status code.");

	a_fault_no_map: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != cplm_pkg::STAT_OK |-> mapped_value == 16'd0)
		else $error("Validation result carries a mapped value.");

endmodule

bind circular_piecewise_linear_map cplm_checker u_cplm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.mapped_value (mapped_value),
	.status       (status)
);
